>>> rtl/core/barometric_pressure_compensation_core_defines.svh
// Assertion macros shared by the barometric compensation RTL.
// No dependencies; expects i_clk and i_rst_n in the using module.
`ifndef BAROMETRIC_PRESSURE_COMPENSATION_CORE_DEFINES_SVH
`define BAROMETRIC_PRESSURE_COMPENSATION_CORE_DEFINES_SVH

// implication checked on every clock edge outside reset
`define BPC_ASSERT_IMP(lbl, a, c, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (a) |-> (c)) \
        else $error(msg);

// next-cycle implication
`define BPC_ASSERT_NXT(lbl, a, c, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (a) |=> (c)) \
        else $error(msg);

`endif

>>> rtl/core/bpc_pkg.sv
// Package for the barometric compensation core: types, constants, helpers.
// No dependencies.
package bpc_pkg;

    localparam int unsigned Oversampling = 0;
    localparam logic [1:0]  Oss          = 2'(Oversampling % 4);

    localparam logic [2:0] REG_AC1 = 3'd0;
    localparam logic [2:0] REG_AC2 = 3'd1;
    localparam logic [2:0] REG_AC3 = 3'd2;
    localparam logic [2:0] REG_AC4 = 3'd3;
    localparam logic [2:0] REG_B1  = 3'd4;
    localparam logic [2:0] REG_B2  = 3'd5;
    localparam logic [2:0] REG_TLP = 3'd6;
    localparam logic [2:0] REG_TCP = 3'd7;

    localparam logic CMD_TEMP  = 1'b0;
    localparam logic CMD_PRESS = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_DONE
    } t_state;

    // divider control/status between core and divider
    typedef struct packed {
        logic        start;
        logic [31:0] num;
        logic [31:0] den;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [31:0] quo;
    } t_div_rsp;

    function automatic logic [31:0] sx16(input logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

    function automatic logic [31:0] asr(input logic [31:0] v, input logic [4:0] n);
        return 32'($signed(v) >>> n);
    endfunction

endpackage

>>> rtl/core/bpc_div.sv
// Radix-2 restoring unsigned divider, 32 bits, one quotient bit per cycle.
// Depends on bpc_pkg.
module bpc_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  bpc_pkg::t_div_req i_req,
    output bpc_pkg::t_div_rsp o_rsp
);
    import bpc_pkg::*;

    logic [31:0] r_rem, n_rem;
    logic [31:0] r_quo, n_quo;
    logic [31:0] r_den, n_den;
    logic [5:0]  r_cnt, n_cnt;
    logic        r_busy, n_busy;
    logic        r_done, n_done;
    logic [32:0] trial;

    always_comb begin
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_den  = r_den;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        trial  = {r_rem, r_quo[31]} - {1'b0, r_den};
        if (i_req.start) begin
            n_rem  = '0;
            n_quo  = i_req.num;
            n_den  = i_req.den;
            n_cnt  = 6'd0;
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (!trial[32]) begin
                n_rem = trial[31:0];
                n_quo = {r_quo[30:0], 1'b1};
            end else begin
                n_rem = {r_rem[30:0], r_quo[31]};
                n_quo = {r_quo[30:0], 1'b0};
            end
            n_cnt = r_cnt + 6'd1;
            if (r_cnt == 6'd31) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_den <= n_den;
    end

    // done pulses for one cycle; quotient holds until the next start
    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;

endmodule

>>> rtl/core/barometric_pressure_compensation_core.sv
// Barometric compensation core: shared 32x32 multiplier and bpc_div under a step counter.
// Temperature and pressure requests each include a bpc_div divide, skipped on a zero
// divisor. One request is processed at a time: a new one is taken only in ST_IDLE,
// and a held result stalls the next in ST_DONE.
// Reset (synchronous, active low) clears coefficients, stored B5 and control.
// Depends on bpc_pkg, bpc_div and the defines header.
`include "barometric_pressure_compensation_core_defines.svh"
module barometric_pressure_compensation_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write port
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    // request channel
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_cmd,
    input  logic [18:0] i_raw_reading,
    // result channel
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_reading_kind,
    output logic [31:0] o_compensated_value,
    output logic        o_status
);
    import bpc_pkg::*;

    // coefficient registers
    logic [15:0] r_ac1, r_ac2, r_ac3, r_ac4, r_b1, r_b2;
    logic [31:0] r_tlp, r_tcp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ac1 <= '0; r_ac2 <= '0; r_ac3 <= '0; r_ac4 <= '0;
            r_b1  <= '0; r_b2  <= '0; r_tlp <= '0; r_tcp <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_AC1: r_ac1 <= i_cfg_data[15:0];
                REG_AC2: r_ac2 <= i_cfg_data[15:0];
                REG_AC3: r_ac3 <= i_cfg_data[15:0];
                REG_AC4: r_ac4 <= i_cfg_data[15:0];
                REG_B1:  r_b1  <= i_cfg_data[15:0];
                REG_B2:  r_b2  <= i_cfg_data[15:0];
                REG_TLP: r_tlp <= i_cfg_data;
                REG_TCP: r_tcp <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Sequencer: r_step walks the microcode in ST_MUL. The multiplier has
    // its operands and product registered, so a product loaded in step k is
    // read in step k+2. Divides leave ST_MUL for ST_DIV and resume at the
    // step after the one that started them.
    t_state      r_state, n_state;
    logic [4:0]  r_step, n_step;
    logic        r_kind, n_kind;
    logic [18:0] r_raw, n_raw;
    logic [31:0] r_x1, n_x1;
    logic [31:0] r_x3, n_x3;
    logic [31:0] r_b5, n_b5;   // stored B5 term
    logic [31:0] r_b6, n_b6;
    logic [31:0] r_sq, n_sq;
    logic [31:0] r_b3, n_b3;
    logic [31:0] r_b4, n_b4;
    logic [31:0] r_p, n_p;
    logic [31:0] r_den, n_den;
    logic        r_dneg, n_dneg;    // temperature quotient is negative
    logic        r_dpost, n_dpost;  // B7 had bit 31 set: shift after divide
    logic [31:0] r_mul_a, n_mul_a;
    logic [31:0] r_mul_b, n_mul_b;
    logic [31:0] r_prod;
    logic [31:0] r_val, n_val;      // finished value, waits in ST_DONE
    logic        r_stat, n_stat;
    // output register, parts the sequencer from the result channel
    logic        r_ovld, n_ovld;
    logic        r_okind, n_okind;
    logic [31:0] r_oval, n_oval;
    logic        r_ostat, n_ostat;

    logic        div_go, calc_end, out_load;
    t_div_req    div_req;
    t_div_rsp    div_rsp;

    bpc_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (div_req),
        .o_rsp  (div_rsp)
    );

    logic [31:0] ac5, ac6, mc, md;
    assign ac5 = {16'd0, r_tlp[31:16]};
    assign ac6 = {16'd0, r_tlp[15:0]};
    assign mc  = sx16(r_tcp[31:16]);
    assign md  = sx16(r_tcp[15:0]);

    logic [31:0] num_t, mag_num, mag_den, x1_t, x2_t, b5_t, b6_t, px3_t, p_t;
    assign num_t   = mc << 11;
    assign mag_num = num_t[31] ? 32'd0 - num_t : num_t;
    assign mag_den = r_den[31] ? 32'd0 - r_den : r_den;
    assign x1_t    = asr(r_prod, 5'd15);
    assign x2_t    = r_dneg ? 32'd0 - div_rsp.quo : div_rsp.quo;
    assign b5_t    = r_x1 + x2_t;
    assign b6_t    = r_b5 - 32'd4000;
    assign px3_t   = asr(r_x1 + asr(r_prod, 5'd16) + 32'd2, 5'd2);
    assign p_t     = r_dpost ? (div_rsp.quo << 1) : div_rsp.quo;

    // control outputs
    always_comb begin
        o_ready  = (r_state == ST_IDLE);
        out_load = (r_state == ST_DONE) && (!r_ovld || i_ready);
        div_go   = 1'b0;
        calc_end = 1'b0;
        if (r_state == ST_MUL) begin
            if (!r_kind) begin
                case (r_step)
                    5'd2: begin
                        // zero divisor ends the request with status set
                        if (r_den == 32'd0) calc_end = 1'b1;
                        else div_go = 1'b1;
                    end
                    5'd3: calc_end = 1'b1;
                    default: ;
                endcase
            end else begin
                case (r_step)
                    5'd11: if (r_b4 == 32'd0) calc_end = 1'b1;
                    5'd12: div_go = 1'b1;
                    5'd18: calc_end = 1'b1;
                    default: ;
                endcase
            end
        end
        div_req       = '0;
        div_req.start = div_go;
        // pressure: B7 is the product read in step 12
        div_req.num   = r_kind ? (r_prod[31] ? r_prod : (r_prod << 1)) : mag_num;
        div_req.den   = r_kind ? r_b4 : mag_den;
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (i_valid) n_state = ST_MUL;
            ST_MUL: begin
                if (div_go) n_state = ST_DIV;
                else if (calc_end) n_state = ST_DONE;
            end
            ST_DIV:  if (div_rsp.done) n_state = ST_MUL;
            ST_DONE: if (out_load) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // datapath
    always_comb begin
        n_step  = r_step;
        n_kind  = r_kind;
        n_raw   = r_raw;
        n_x1    = r_x1;
        n_x3    = r_x3;
        n_b5    = r_b5;
        n_b6    = r_b6;
        n_sq    = r_sq;
        n_b3    = r_b3;
        n_b4    = r_b4;
        n_p     = r_p;
        n_den   = r_den;
        n_dneg  = r_dneg;
        n_dpost = r_dpost;
        n_mul_a = r_mul_a;
        n_mul_b = r_mul_b;
        n_val   = r_val;
        n_stat  = r_stat;
        n_ovld  = r_ovld && !i_ready;
        n_okind = r_okind;
        n_oval  = r_oval;
        n_ostat = r_ostat;
        if (out_load) begin
            n_ovld  = 1'b1;
            n_okind = r_kind;
            n_oval  = r_val;
            n_ostat = r_stat;
        end
        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_kind  = i_cmd;
                    n_raw   = i_raw_reading;
                    n_step  = 5'd0;
                    n_mul_a = {13'd0, i_raw_reading} - ac6;
                    n_mul_b = ac5;
                end
            end
            ST_MUL: begin
                n_step = r_step + 5'd1;
                if (!r_kind) begin
                    case (r_step)
                        5'd1: begin
                            n_x1  = x1_t;
                            n_den = x1_t + md;
                        end
                        5'd2: begin
                            n_dneg = num_t[31] ^ r_den[31];
                            n_val  = '0;
                            n_stat = 1'b1;
                        end
                        5'd3: begin
                            n_b5   = b5_t;
                            n_val  = asr(b5_t + 32'd8, 5'd4);
                            n_stat = 1'b0;
                        end
                        default: ;
                    endcase
                end else begin
                    case (r_step)
                        5'd0: begin
                            n_b6    = b6_t;
                            n_mul_a = b6_t;
                            n_mul_b = b6_t;
                        end
                        5'd2: begin
                            n_sq    = asr(r_prod, 5'd12);
                            n_mul_a = sx16(r_b2);
                            n_mul_b = asr(r_prod, 5'd12);
                        end
                        5'd3: begin
                            n_mul_a = sx16(r_ac2);
                            n_mul_b = r_b6;
                        end
                        5'd4: n_x1 = asr(r_prod, 5'd11);
                        5'd5: begin
                            n_x3    = r_x1 + asr(r_prod, 5'd11);
                            n_mul_a = sx16(r_ac3);
                            n_mul_b = r_b6;
                        end
                        5'd6: begin
                            n_b3    = asr((((sx16(r_ac1) << 2) + r_x3) << Oss) + 32'd2,
                                          5'd2);
                            n_mul_a = sx16(r_b1);
                            n_mul_b = r_sq;
                        end
                        5'd7: n_x1 = asr(r_prod, 5'd13);
                        5'd8: begin
                            n_x3    = px3_t;
                            n_mul_a = {16'd0, r_ac4};
                            n_mul_b = px3_t + 32'd32768;
                        end
                        5'd10: begin
                            n_b4    = r_prod >> 15;
                            n_mul_a = {13'd0, r_raw} - r_b3;
                            n_mul_b = 32'd50000 >> Oss;
                        end
                        5'd11: begin
                            n_val  = '0;
                            n_stat = 1'b1;
                        end
                        5'd12: n_dpost = r_prod[31];
                        5'd13: begin
                            n_p     = p_t;
                            n_mul_a = asr(p_t, 5'd8);
                            n_mul_b = asr(p_t, 5'd8);
                        end
                        5'd15: begin
                            n_mul_a = r_prod;
                            n_mul_b = 32'd3038;
                        end
                        5'd16: begin
                            n_mul_a = 32'd0 - 32'd7357;
                            n_mul_b = r_p;
                        end
                        5'd17: n_x1 = asr(r_prod, 5'd16);
                        5'd18: begin
                            n_val  = r_p + asr(r_x1 + asr(r_prod, 5'd16) + 32'd3791, 5'd4);
                            n_stat = 1'b0;
                        end
                        default: ;
                    endcase
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step  <= '0;
            r_b5    <= '0;
            r_ovld  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            r_b5    <= n_b5;
            r_ovld  <= n_ovld;
        end
        r_kind  <= n_kind;
        r_raw   <= n_raw;
        r_x1    <= n_x1;
        r_x3    <= n_x3;
        r_b6    <= n_b6;
        r_sq    <= n_sq;
        r_b3    <= n_b3;
        r_b4    <= n_b4;
        r_p     <= n_p;
        r_den   <= n_den;
        r_dneg  <= n_dneg;
        r_dpost <= n_dpost;
        r_mul_a <= n_mul_a;
        r_mul_b <= n_mul_b;
        r_prod  <= r_mul_a * r_mul_b;
        r_val   <= n_val;
        r_stat  <= n_stat;
        r_okind <= n_okind;
        r_oval  <= n_oval;
        r_ostat <= n_ostat;
    end

    assign o_valid             = r_ovld;
    assign o_reading_kind      = r_okind;
    assign o_compensated_value = r_oval;
    assign o_status            = r_ostat;

    `BPC_ASSERT_IMP(a_busy_not_ready, r_state != ST_IDLE, !o_ready, "ready while busy")
    `BPC_ASSERT_IMP(a_zero_div_val, r_ovld && r_ostat, r_oval == '0, "zero divisor value")
    `BPC_ASSERT_NXT(a_accept_busy, i_valid && o_ready, !o_ready, "ready after accept")
    `BPC_ASSERT_NXT(a_out_hold, r_ovld && !i_ready, r_ovld && $stable(r_oval), "result moved")

endmodule
